>>> sv/ctp_pkg.sv
// shared types and constants for the columnar transposition core
package ctp_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int BYTE_W      = 8;
  localparam int WIDTH_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b1;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST = 7'd6;
  localparam logic               DIR_ENCODE    = 1'b0;
  localparam logic               DIR_DECODE    = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } ctp_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
  } ctp_out_t;

  typedef struct packed {
    logic start;
    logic step;
  } ctp_walk_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ENC,
    ST_SCATTER,
    ST_GAP,
    ST_DEC_OUT
  } ctp_state_t;

endpackage

>>> sv/ctp_ram.sv
// single write port, single read port synchronous ram with registered read data
module ctp_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ctp_walk.sv
// column-major address walker over a row-major message buffer
module ctp_walk #(
  parameter int AW = 6,
  parameter int CW = 7,
  parameter int WW = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctp_pkg::ctp_walk_ctl_t ctl,
  input  logic [CW-1:0]          len,
  input  logic [WW-1:0]          width,
  output logic [AW-1:0]          idx
);
  import ctp_pkg::*;

  localparam int SW = ((CW > WW) ? CW : WW) + 1;

  logic [AW-1:0] col;
  logic [SW-1:0] sum;

  assign sum = SW'(idx) + SW'(width);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      col <= '0;
    end else if (ctl.start) begin
      idx <= '0;
      col <= '0;
    end else if (ctl.step) begin
      if (sum >= SW'(len)) begin
        // column exhausted, move to the head of the next one
        col <= col + 1'b1;
        idx <= col + 1'b1;
      end else begin
        idx <= sum[AW-1:0];
      end
    end
  end

endmodule

>>> sv/columnar_transposition_core.sv
// Unkeyed columnar transposition core. Message bytes are taken one per cycle into a
// MAX_LEN-byte store until a beat marked last; bytes past MAX_LEN are dropped. The item
// port then stalls while the permuted message is read back. Encode reads the store in
// column order, one byte per cycle, and the core takes the next message once the last
// byte is issued. Decode first scatters the message into a second ram through the same
// column walk, with a turnaround state for the last write, then reads that ram in order
// at one byte per cycle. Each ram has a single read port. Result stalls pause the
// output reads in both modes once the two-beat output buffer is full. Row width 0
// acts as 1.
module columnar_transposition_core #(
  parameter int MAX_LEN = ctp_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  ctp_pkg::ctp_in_t                item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output ctp_pkg::ctp_out_t               result
);
  import ctp_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  ctp_state_t           state, state_next;
  logic [WIDTH_W-1:0]   row_width;
  logic                 direction;
  logic [WIDTH_W-1:0]   eff_width;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        len;
  logic [CW-1:0]        pos;
  logic                 rd_valid;
  logic                 rd_last;
  logic                 rd_from_perm;
  logic                 scat_we;
  logic [AW-1:0]        scat_addr;
  logic                 skid_valid;
  ctp_out_t             skid;

  ctp_walk_ctl_t        walk_ctl;
  logic [AW-1:0]        walk_idx;
  logic [AW-1:0]        store_raddr;
  logic [BYTE_W-1:0]    store_rdata;
  logic [BYTE_W-1:0]    perm_rdata;
  logic                 item_acc;
  logic                 has_room;
  logic                 store_we;
  logic                 last_pos;
  logic                 issue;
  logic                 issue_perm;
  logic                 scat;
  logic                 pos_clr;
  logic                 pos_inc;
  logic                 pop;
  logic [1:0]           occ;
  logic                 can_issue;
  ctp_out_t             rd_item;

  assign cfg_ready = 1'b1;
  assign eff_width = (row_width == '0) ? WIDTH_W'(1) : row_width;
  assign item_acc  = item_valid && !item_stall;
  assign has_room  = fill < CW'(MAX_LEN);
  assign store_we  = item_acc && has_room;
  assign last_pos  = pos == (len - 1'b1);
  assign pop       = result_valid && !result_stall;
  assign occ       = 2'(result_valid) + 2'(skid_valid) + 2'(rd_valid);
  assign can_issue = (occ - 2'(pop)) < 2'd2;

  assign rd_item.out_byte = rd_from_perm ? perm_rdata : store_rdata;
  assign rd_item.out_last = rd_last;

  ctp_ram #(.DEPTH(MAX_LEN), .AW(AW), .DW(BYTE_W)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill[AW-1:0]),
    .wdata (item.in_byte),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  ctp_ram #(.DEPTH(MAX_LEN), .AW(AW), .DW(BYTE_W)) u_perm (
    .clk   (clk),
    .we    (scat_we),
    .waddr (scat_addr),
    .wdata (store_rdata),
    .raddr (pos[AW-1:0]),
    .rdata (perm_rdata)
  );

  ctp_walk #(.AW(AW), .CW(CW), .WW(WIDTH_W)) u_walk (
    .clk   (clk),
    .rst   (rst),
    .ctl   (walk_ctl),
    .len   (len),
    .width (eff_width),
    .idx   (walk_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    item_stall  = 1'b1;
    walk_ctl    = '0;
    store_raddr = walk_idx;
    issue       = 1'b0;
    issue_perm  = 1'b0;
    scat        = 1'b0;
    pos_clr     = 1'b0;
    pos_inc     = 1'b0;
    unique case (state)
      ST_LOAD: begin
        item_stall = 1'b0;
        if (item_valid && item.in_last) begin
          walk_ctl.start = 1'b1;
          pos_clr        = 1'b1;
          state_next     = (direction == DIR_DECODE) ? ST_SCATTER : ST_ENC;
        end
      end
      ST_ENC: begin
        if (can_issue) begin
          issue         = 1'b1;
          walk_ctl.step = 1'b1;
          pos_inc       = 1'b1;
          if (last_pos) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_SCATTER: begin
        store_raddr   = pos[AW-1:0];
        scat          = 1'b1;
        walk_ctl.step = 1'b1;
        pos_inc       = 1'b1;
        if (last_pos) begin
          pos_clr    = 1'b1;
          state_next = ST_GAP;
        end
      end
      ST_GAP: begin
        // last scatter write lands this cycle
        state_next = ST_DEC_OUT;
      end
      ST_DEC_OUT: begin
        if (can_issue) begin
          issue      = 1'b1;
          issue_perm = 1'b1;
          pos_inc    = 1'b1;
          if (last_pos) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RST;
      direction <= DIR_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: row_width <= cfg_data[WIDTH_W-1:0];
        REG_DIRECTION: direction <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      len      <= '0;
      pos      <= '0;
      rd_valid <= 1'b0;
      scat_we  <= 1'b0;
    end else begin
      if (item_acc) begin
        if (item.in_last) begin
          len  <= fill + CW'(has_room);
          fill <= '0;
        end else if (has_room) begin
          fill <= fill + 1'b1;
        end
      end
      if (pos_clr) begin
        pos <= '0;
      end else if (pos_inc) begin
        pos <= pos + 1'b1;
      end
      rd_valid <= issue;
      scat_we  <= scat;
    end
  end

  always_ff @(posedge clk) begin
    rd_last      <= last_pos;
    rd_from_perm <= issue_perm;
    scat_addr    <= walk_idx;
  end

  // two-beat output buffer: result register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || pop) begin
      if (skid_valid) begin
        result       <= skid;
        result_valid <= 1'b1;
        if (rd_valid) begin
          skid <= rd_item;
        end else begin
          skid_valid <= 1'b0;
        end
      end else begin
        result       <= rd_item;
        result_valid <= rd_valid;
      end
    end else if (rd_valid) begin
      skid       <= rd_item;
      skid_valid <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a beat while the result register is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && skid_valid) |-> (result_valid && !result_stall))
    else $error("read data arrives with no free buffer slot");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_LEN))
    else $error("fill count beyond buffer depth");

  a_scatter_window: assert property (@(posedge clk) disable iff (rst)
    scat_we |-> (state == ST_SCATTER || state == ST_GAP))
    else $error("scatter write outside the decode scatter pass");
`endif

endmodule

>>> verif/columnar_transposition_checker.sv
// checker for the columnar transposition core: predicts each permuted byte and compares beats
`timescale 1ns / 1ps
module columnar_transposition_checker #(
  parameter int MAX_LEN = ctp_pkg::MAX_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  ctp_pkg::ctp_in_t               item,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  ctp_pkg::ctp_out_t              result,
  output int                             fail_count,
  output int                             pending,
  output int                             bytes_checked
);
  import ctp_pkg::*;

  logic [BYTE_W-1:0]  held [MAX_LEN];
  int                 held_count = 0;
  logic [WIDTH_W-1:0] columns = ROW_WIDTH_RST;
  logic               direction = DIR_ENCODE;
  ctp_out_t           due_bytes [$];
  int                 errors = 0;
  int                 checked = 0;

  task automatic permute_message();
    int       len, w, p, c, idx;
    int       order [MAX_LEN];
    ctp_out_t perm [MAX_LEN];
    len = held_count;
    w = (columns == 0) ? 1 : int'(columns);
    p = 0;
    // column-major walk over the row-major store, short last row skipped
    for (c = 0; c < w && p < len; c++) begin
      for (idx = c; idx < len; idx += w) begin
        order[p] = idx;
        p++;
      end
    end
    for (p = 0; p < len; p++) begin
      if (direction == DIR_ENCODE) begin
        perm[p].out_byte = held[order[p]];
      end else begin
        perm[order[p]].out_byte = held[p];
      end
    end
    for (p = 0; p < len; p++) begin
      perm[p].out_last = (p == len - 1);
      due_bytes = {due_bytes, perm[p]};
    end
    held_count = 0;
  endtask

  task automatic compare_beat();
    ctp_out_t want;
    logic     bad;
    if (due_bytes.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, got byte %h last %b",
               $time, result.out_byte, result.out_last);
      errors++;
    end else begin
      want = due_bytes.pop_front();
      bad = 1'b0;
      if (result.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h, got %h",
                 $time, want.out_byte, result.out_byte);
        bad = 1'b1;
      end
      if (result.out_last !== want.out_last) begin
        $display("%0t: out_last mismatch: expected %b, got %b",
                 $time, want.out_last, result.out_last);
        bad = 1'b1;
      end
      if (bad) begin
        errors++;
      end
      checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      columns = ROW_WIDTH_RST;
      direction = DIR_ENCODE;
      due_bytes.delete();
    end else begin
      if (result_valid && !result_stall) begin
        compare_beat();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_WIDTH: columns = cfg_data[WIDTH_W-1:0];
          REG_DIRECTION: direction = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        // bytes past the store are dropped, a last one still triggers output
        if (held_count < MAX_LEN) begin
          held[held_count] = item.in_byte;
          held_count++;
        end
        if (item.in_last) begin
          permute_message();
        end
      end
    end
    fail_count <= errors;
    pending <= due_bytes.size();
    bytes_checked <= checked;
  end

endmodule

>>> verif/columnar_transposition_core_test.sv
// testbench top for the columnar transposition core: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps
module columnar_transposition_core_test;
  import ctp_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int TARGET_BEATS = 210;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ROW_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  ctp_in_t               item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  ctp_out_t              result;
  int                    fail_count;
  int                    pending;
  int                    bytes_checked;

  logic [BYTE_W-1:0] msg [$];
  int                beats_sent = 0;
  int                messages_sent = 0;
  int                long_messages = 0;
  int                decode_messages = 0;
  int                cfg_writes = 0;
  logic              cur_dir = DIR_ENCODE;
  int                idle_cycles = 0;
  int                stall_left = 0;
  logic              rx_quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  columnar_transposition_core uut (.*);

  columnar_transposition_checker checker_i (.*);

  // receiver: random stall after each beat, with spells of no stalling
  always @(posedge clk) begin : rx_side
    int n;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
      rx_quiet <= 1'b0;
    end else if (result_valid && !result_stall) begin
      n = rx_quiet ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0) begin
        rx_quiet <= !rx_quiet;
      end
      stall_left <= n;
      result_stall <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [WIDTH_W-1:0] w, input logic d);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROW_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_DIRECTION;
    cfg_data <= CFG_DATA_W'(d);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes += 2;
    cur_dir = d;
  endtask

  task automatic send_message();
    int   i, gap;
    logic quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (i = 0; i < msg.size(); i++) begin
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      item_valid <= 1'b1;
      item <= ctp_in_t'{in_byte: msg[i], in_last: (i == msg.size() - 1)};
      @(posedge clk);
      while (item_stall) @(posedge clk);
      beats_sent++;
    end
    item_valid <= 1'b0;
    @(posedge clk);
    messages_sent++;
    if (msg.size() > MAX_LEN_DEF) begin
      long_messages++;
    end
    if (cur_dir == DIR_DECODE) begin
      decode_messages++;
    end
  endtask

  task automatic random_message(input int n);
    msg.delete();
    repeat (n) msg = {msg, 8'($urandom_range(0, 255))};
  endtask

  initial begin
    int                 n;
    logic [WIDTH_W-1:0] w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: width 6, encode
    msg = {8'hFF};
    send_message();
    msg = {8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hAA, 8'h55};
    send_message();
    write_cfg(7'd3, DIR_DECODE);
    msg = {8'h10, 8'h21, 8'h32, 8'h43, 8'h54, 8'h65, 8'h76};
    send_message();
    // width zero acts as one
    write_cfg(7'd0, DIR_ENCODE);
    msg = {8'hC3, 8'h3C, 8'h99};
    send_message();
    // width beyond the message length
    write_cfg(7'd127, DIR_DECODE);
    msg = {8'h01, 8'h02, 8'h04};
    send_message();
    write_cfg(7'd64, DIR_ENCODE);
    msg = {8'hEE, 8'h11};
    send_message();

    while (beats_sent < TARGET_BEATS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0: w = 7'd1;
          1: w = 7'd64;
          2: w = 7'd0;
          3: w = 7'($urandom_range(65, 127));
          default: w = 7'($urandom_range(2, 16));
        endcase
        write_cfg(w, 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 5) == 0) begin
        drain();
      end
      // now and then a message near or past the store size
      if ($urandom_range(0, 15) == 0 || messages_sent % 12 == 5) begin
        n = $urandom_range(62, 70);
      end else begin
        n = $urandom_range(1, 16);
      end
      random_message(n);
      send_message();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d bytes in %0d messages (%0d decoded, %0d overrunning the store), %0d reg writes",
             beats_sent, messages_sent, decode_messages, long_messages, cfg_writes);
    $display("%0d permuted bytes compared", bytes_checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
